/* hw/rtl/imu_rate_and_tilt_from_raw_macros.svh */
// assertion macros for the imu rate and tilt block
// used by the checker; expects clk_i and rst_ni in scope
`ifndef IMU_RATE_AND_TILT_FROM_RAW_MACROS_SVH
`define IMU_RATE_AND_TILT_FROM_RAW_MACROS_SVH

// same-cycle implication
`define IMURT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMURT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/imurt_pkg.sv */
// shared types, constants and the arctangent table for the imu rate and tilt block
// no dependencies
package imurt_pkg;

  localparam int unsigned SqrtSteps   = 32;
  localparam int unsigned CordicSteps = 22;

  // 2^31 / 131 rounded up, exact for the rate numerator range
  localparam logic [23:0] RateRecip = 24'd16393005;

  localparam logic [15:0]        AngleLimit = 16'd23040;
  localparam logic signed [15:0] AngleMax   = 16'sd23040;
  localparam logic signed [15:0] AngleMin   = -16'sd23040;
  localparam logic signed [15:0] RateMax    = 16'sd32017;
  localparam logic signed [15:0] RateMin    = -16'sd32018;

  typedef logic [2:0][15:0] rate3_t;

  typedef struct packed {
    logic signed [15:0] a;
    logic [31:0]        sum;
    logic [33:0]        rem;
    logic [31:0]        root;
  } sq_lane_t;

  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [28:0] z;
    logic               xzero;
    logic               yzero;
    logic               yneg;
  } co_lane_t;

  typedef struct packed {
    rate3_t      rates;
    logic [15:0] roll;
    logic [15:0] pitch;
  } res_t;

  // atan(2^-i) in degrees, 2^-20 units
  function automatic logic [26:0] atan_entry(input logic [4:0] i);
    logic [26:0] r;
    case (i)
      5'd0:    r = 27'd47185920;
      5'd1:    r = 27'd27855475;
      5'd2:    r = 27'd14718068;
      5'd3:    r = 27'd7471121;
      5'd4:    r = 27'd3750058;
      5'd5:    r = 27'd1876857;
      5'd6:    r = 27'd938658;
      5'd7:    r = 27'd469357;
      5'd8:    r = 27'd234682;
      5'd9:    r = 27'd117342;
      5'd10:   r = 27'd58671;
      5'd11:   r = 27'd29335;
      5'd12:   r = 27'd14668;
      5'd13:   r = 27'd7334;
      5'd14:   r = 27'd3667;
      5'd15:   r = 27'd1833;
      5'd16:   r = 27'd917;
      5'd17:   r = 27'd458;
      5'd18:   r = 27'd229;
      5'd19:   r = 27'd115;
      5'd20:   r = 27'd57;
      5'd21:   r = 27'd29;
      default: r = 27'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/imu_rate_and_tilt_from_raw.sv */
// imu rate and tilt top level: gyro scaling, square root and arctangent pipeline
// depends on imurt_pkg, imurt_sqrt_stage, imurt_cordic_stage
//
//   channel | direction | handshake                | fields
//   in      | input     | in_valid_i / in_stall_o  | accel_{x,y,z}_raw_i, gyro_{x,y,z}_raw_i
//   out     | output    | out_valid_o / out_stall_i| {roll,pitch,yaw}_rate_o, {roll,pitch}_angle_o
//
// one transaction per cycle sustained while the output is not stalled
// the pipeline runs the 32 square root stages and 22 arctangent stages in series
// reset clears only the valid bits, the output valid and the skid flag
// a stalled output fills a one-entry skid; in_stall_o is that flag, registered,
// and the whole pipeline holds while it is set
module imu_rate_and_tilt_from_raw import imurt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] accel_x_raw_i,
  input  logic signed [15:0] accel_y_raw_i,
  input  logic signed [15:0] accel_z_raw_i,
  input  logic signed [15:0] gyro_x_raw_i,
  input  logic signed [15:0] gyro_y_raw_i,
  input  logic signed [15:0] gyro_z_raw_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] roll_rate_o,
  output logic signed [15:0] pitch_rate_o,
  output logic signed [15:0] yaw_rate_o,
  output logic signed [15:0] roll_angle_o,
  output logic signed [15:0] pitch_angle_o
);

  logic en;
  logic skid_full_q;

  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  // stage 1: magnitudes for the rates, squares for the angles
  logic               s1_v_q;
  logic [2:0]         s1_neg_q;
  logic [2:0][22:0]   s1_num_q;
  logic [30:0]        s1_sqx_q, s1_sqy_q, s1_sqz_q;
  logic signed [15:0] s1_ax_q, s1_ay_q;

  logic [2:0][15:0] g_in;
  logic [2:0][16:0] g_abs;
  logic [31:0]      sqx, sqy, sqz;

  always_comb begin
    g_in = {gyro_z_raw_i, gyro_y_raw_i, gyro_x_raw_i};
    for (int g = 0; g < 3; g++) begin
      g_abs[g] = g_in[g][15] ? 17'(~{1'b1, g_in[g]} + 17'd1) : {1'b0, g_in[g]};
    end
    sqx = 32'(accel_x_raw_i * accel_x_raw_i);
    sqy = 32'(accel_y_raw_i * accel_y_raw_i);
    sqz = 32'(accel_z_raw_i * accel_z_raw_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        s1_neg_q[g] <= g_in[g][15];
        // magnitude of the most negative count needs only 16 of the 17 bits
        s1_num_q[g] <= 23'({g_abs[g], 7'd0}) + 23'd65;
      end
      s1_sqx_q <= sqx[30:0];
      s1_sqy_q <= sqy[30:0];
      s1_sqz_q <= sqz[30:0];
      s1_ax_q  <= accel_x_raw_i;
      s1_ay_q  <= accel_y_raw_i;
    end
  end

  // stage 2: divide by 131 through the reciprocal, sum the squares
  logic     s2_v_q;
  rate3_t   s2_rt_q;
  sq_lane_t s2_lane_q [2];

  logic [2:0][46:0] prod;
  rate3_t           rate_d;

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      prod[g]   = 47'(s1_num_q[g] * RateRecip);
      rate_d[g] = s1_neg_q[g] ? 16'(-prod[g][46:31]) : prod[g][46:31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_rt_q <= rate_d;
      s2_lane_q[0] <= '{a: s1_ay_q, sum: {1'b0, s1_sqx_q} + {1'b0, s1_sqz_q},
                        rem: '0, root: '0};
      s2_lane_q[1] <= '{a: s1_ax_q, sum: {1'b0, s1_sqy_q} + {1'b0, s1_sqz_q},
                        rem: '0, root: '0};
    end
  end

  // square root of sum * 2^32, one root bit per stage
  logic     sq_v_q  [SqrtSteps];
  rate3_t   sq_rt_q [SqrtSteps];
  sq_lane_t sq_q    [SqrtSteps][2];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    logic     vin;
    rate3_t   rin;
    sq_lane_t lin  [2];
    sq_lane_t lout [2];

    if (k == 0) begin : g_first
      assign vin     = s2_v_q;
      assign rin     = s2_rt_q;
      assign lin[0]  = s2_lane_q[0];
      assign lin[1]  = s2_lane_q[1];
    end else begin : g_next
      assign vin     = sq_v_q[k-1];
      assign rin     = sq_rt_q[k-1];
      assign lin[0]  = sq_q[k-1][0];
      assign lin[1]  = sq_q[k-1][1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [1:0] pair;
      // the low half of the radicand is all zero
      if (k < 16) begin : g_hi
        assign pair = lin[l].sum[(15-k)*2 +: 2];
      end else begin : g_lo
        assign pair = 2'b00;
      end
      imurt_sqrt_stage u_step (
        .lane_i (lin[l]),
        .pair_i (pair),
        .lane_o (lout[l])
      );
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rt_q[k] <= rin;
        sq_q[k][0] <= lout[0];
        sq_q[k][1] <= lout[1];
      end
    end
  end

  // arctangent by vectoring rotations
  logic     co_v_q  [CordicSteps];
  rate3_t   co_rt_q [CordicSteps];
  co_lane_t co_q    [CordicSteps][2];

  co_lane_t co_init [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      co_init[l].x     = {4'd0, sq_q[SqrtSteps-1][l].root};
      co_init[l].y     = {{4{sq_q[SqrtSteps-1][l].a[15]}}, sq_q[SqrtSteps-1][l].a, 16'd0};
      co_init[l].z     = '0;
      co_init[l].xzero = (sq_q[SqrtSteps-1][l].root == '0);
      co_init[l].yzero = (sq_q[SqrtSteps-1][l].a == '0);
      co_init[l].yneg  = sq_q[SqrtSteps-1][l].a[15];
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    logic     vin;
    rate3_t   rin;
    co_lane_t lin  [2];
    co_lane_t lout [2];

    if (i == 0) begin : g_first
      assign vin    = sq_v_q[SqrtSteps-1];
      assign rin    = sq_rt_q[SqrtSteps-1];
      assign lin[0] = co_init[0];
      assign lin[1] = co_init[1];
    end else begin : g_next
      assign vin    = co_v_q[i-1];
      assign rin    = co_rt_q[i-1];
      assign lin[0] = co_q[i-1][0];
      assign lin[1] = co_q[i-1][1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      imurt_cordic_stage u_step (
        .lane_i (lin[l]),
        .step_i (5'(i)),
        .lane_o (lout[l])
      );
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        co_v_q[i] <= 1'b0;
      end else if (en) begin
        co_v_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        co_rt_q[i] <= rin;
        co_q[i][0] <= lout[0];
        co_q[i][1] <= lout[1];
      end
    end
  end

  // final stage: round to 1/256 degree, clamp, special cases
  logic fin_v_q;
  res_t fin_q;

  logic [1:0][28:0] zabs;
  logic [1:0][28:0] zrnd;
  logic [1:0][16:0] mag;
  logic [1:0][15:0] magc;
  logic [1:0][15:0] ang;
  res_t             fin_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      zabs[l] = co_q[CordicSteps-1][l].z[28] ? 29'(-co_q[CordicSteps-1][l].z)
                                             : co_q[CordicSteps-1][l].z;
      zrnd[l] = zabs[l] + 29'd2048;
      mag[l]  = zrnd[l][28:12];
      magc[l] = (mag[l] > {1'b0, AngleLimit}) ? AngleLimit : mag[l][15:0];
      if (co_q[CordicSteps-1][l].xzero) begin
        if (co_q[CordicSteps-1][l].yzero) begin
          ang[l] = '0;
        end else begin
          ang[l] = co_q[CordicSteps-1][l].yneg ? AngleMin : AngleMax;
        end
      end else begin
        ang[l] = co_q[CordicSteps-1][l].z[28] ? 16'(-magc[l]) : magc[l];
      end
    end
    fin_d.rates = co_rt_q[CordicSteps-1];
    fin_d.roll  = ang[0];
    fin_d.pitch = 16'(-ang[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= co_v_q[CordicSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  // output register with one-entry skid
  logic out_valid_q;
  res_t out_res_q;
  res_t skid_res_q;
  logic out_take;

  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (out_take) begin
        skid_full_q <= 1'b0;
      end
    end else if (fin_v_q) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_full_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (out_take) begin
        out_res_q <= skid_res_q;
      end
    end else if (fin_v_q) begin
      if (!out_valid_q || out_take) begin
        out_res_q <= fin_q;
      end else begin
        skid_res_q <= fin_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_rate_o   = out_res_q.rates[0];
  assign pitch_rate_o  = out_res_q.rates[1];
  assign yaw_rate_o    = out_res_q.rates[2];
  assign roll_angle_o  = out_res_q.roll;
  assign pitch_angle_o = out_res_q.pitch;

endmodule

/* hw/rtl/imurt_sqrt_stage.sv */
// one result bit of the restoring square root
// depends on imurt_pkg
module imurt_sqrt_stage import imurt_pkg::*; (
  input  sq_lane_t   lane_i,
  input  logic [1:0] pair_i,
  output sq_lane_t   lane_o
);

  logic [35:0] acc;
  logic [35:0] trial;
  logic        fits;

  always_comb begin
    acc    = {lane_i.rem, pair_i};
    trial  = {2'b00, lane_i.root, 2'b01};
    fits   = (acc >= trial);
    lane_o = lane_i;
    lane_o.root = {lane_i.root[30:0], fits};
    lane_o.rem  = fits ? 34'(acc - trial) : acc[33:0];
  end

endmodule

/* hw/rtl/imurt_cordic_stage.sv */
// one vectoring rotation of the arctangent
// depends on imurt_pkg
module imurt_cordic_stage import imurt_pkg::*; (
  input  co_lane_t   lane_i,
  input  logic [4:0] step_i,
  output co_lane_t   lane_o
);

  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic signed [28:0] ang;

  always_comb begin
    xs  = lane_i.x >>> step_i;
    ys  = lane_i.y >>> step_i;
    ang = signed'({2'b00, atan_entry(step_i)});
    lane_o = lane_i;
    if (!lane_i.y[35]) begin
      lane_o.x = lane_i.x + ys;
      lane_o.y = lane_i.y - xs;
      lane_o.z = lane_i.z + ang;
    end else begin
      lane_o.x = lane_i.x - ys;
      lane_o.y = lane_i.y + xs;
      lane_o.z = lane_i.z - ang;
    end
  end

endmodule

/* hw/rtl/imurt_checker.sv */
// port-level checks for the imu rate and tilt block, bound to the top level
// depends on imurt_pkg and imu_rate_and_tilt_from_raw_macros.svh
`include "imu_rate_and_tilt_from_raw_macros.svh"

module imurt_checker import imurt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] roll_rate_o,
  input logic signed [15:0] pitch_rate_o,
  input logic signed [15:0] yaw_rate_o,
  input logic signed [15:0] roll_angle_o,
  input logic signed [15:0] pitch_angle_o
);

  // a stalled transaction keeps its payload
  `IMURT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(roll_rate_o) && $stable(pitch_rate_o) && $stable(yaw_rate_o) && $stable(roll_angle_o) && $stable(pitch_angle_o), "output changed while stalled")

  `IMURT_ASSERT_NOW(a_angle_range, out_valid_o, roll_angle_o <= AngleMax && roll_angle_o >= AngleMin && pitch_angle_o <= AngleMax && pitch_angle_o >= AngleMin, "angle outside plus or minus 90 degrees")

  `IMURT_ASSERT_NOW(a_rate_range, out_valid_o, roll_rate_o <= RateMax && roll_rate_o >= RateMin && pitch_rate_o <= RateMax && pitch_rate_o >= RateMin && yaw_rate_o <= RateMax && yaw_rate_o >= RateMin, "rate out of range")

  // input back-pressure only follows a stalled output
  `IMURT_ASSERT_NOW(a_stall_cause, $rose(in_stall_o), $past(out_valid_o && out_stall_i), "input stalled without output stall")

endmodule

bind imu_rate_and_tilt_from_raw imurt_checker u_imurt_checker (.*);
